FILE: rtl/core/thermistor_beta_temperature_unit_macros.svh
// Assertion helpers for the thermistor temperature unit.
`ifndef THERMISTOR_BETA_TEMPERATURE_UNIT_MACROS_SVH
`define THERMISTOR_BETA_TEMPERATURE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TBT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbt assertion failed");
`define TBT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbt assertion failed");
`else
`define TBT_ASSERT_IMP(label, ante, cons)
`define TBT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/tbt_pkg.sv
`timescale 1ns / 1ps
package tbt_pkg;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_MUL,
        ST_DIV1_GO,
        ST_DIV1,
        ST_LOG_GO,
        ST_LOG,
        ST_DIV2_GO,
        ST_DIV2,
        ST_OUT
    } tbt_state_t;

    typedef enum logic [2:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQ,
        LG_SCALE,
        LG_ROUND
    } tbt_lg_state_t;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO_SUM = 2'd1;
    localparam logic [1:0] STAT_LOG_NEG  = 2'd2;
    localparam logic [1:0] STAT_SAT      = 2'd3;

    localparam logic [1:0] CFG_SERIES = 2'd0;
    localparam logic [1:0] CFG_BETA   = 2'd1;
    localparam logic [1:0] CFG_LOG_RX = 2'd2;

    localparam int LN_W = 21;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [15:0] KELVIN_OFFSET = 16'd2730;
    localparam int TEMP_Q_LIMIT = 35497;
    localparam logic [31:0] RES_MAX = 32'hFFFF_FFFF;

endpackage

FILE: rtl/core/tbt_divider.sv
`timescale 1ns / 1ps
module tbt_divider #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 25
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   rem_sh;
    logic             fits;
    logic [DEN_W:0]   rem_next;

    // trial subtract of one quotient bit
    always_comb
    begin
        rem_sh   = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        fits     = (rem_sh >= {1'b0, den_reg});
        rem_next = fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
    end

    // shift one bit per cycle, numerator out at the top, quotient in at the bottom
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= num;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule

FILE: rtl/core/tbt_log.sv
`timescale 1ns / 1ps
module tbt_log (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [31:0]             r,
    output logic                    done,
    output logic [tbt_pkg::LN_W-1:0] ln
);
    import tbt_pkg::*;

    tbt_lg_state_t   state_reg, state_next;
    logic [31:0]     m_reg, m_next;
    logic [4:0]      k_reg, k_next;
    logic [19:0]     frac_reg, frac_next;
    logic [4:0]      it_reg, it_next;
    logic [56:0]     prod_reg, prod_next;
    logic [LN_W-1:0] ln_reg, ln_next;
    logic            done_reg, done_next;

    logic [63:0]     sq;
    logic [32:0]     sq_top;
    logic [56:0]     rounded;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LG_IDLE;
            m_reg     <= '0;
            k_reg     <= '0;
            frac_reg  <= '0;
            it_reg    <= '0;
            prod_reg  <= '0;
            ln_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            m_reg     <= m_next;
            k_reg     <= k_next;
            frac_reg  <= frac_next;
            it_reg    <= it_next;
            prod_reg  <= prod_next;
            ln_reg    <= ln_next;
            done_reg  <= done_next;
        end
    end

    // normalize, square for one fraction bit per cycle, then scale by ln 2 and round
    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        frac_next  = frac_reg;
        it_next    = it_reg;
        prod_next  = prod_reg;
        ln_next    = ln_reg;
        done_next  = 1'b0;
        sq         = {32'd0, m_reg} * {32'd0, m_reg};
        sq_top     = sq[63:31];
        rounded    = prod_reg + (57'd1 << 35);
        case (state_reg)
            LG_IDLE:
            begin
                if (start)
                begin
                    m_next     = r;
                    k_next     = 5'd31;
                    frac_next  = '0;
                    state_next = LG_NORM;
                end
            end
            LG_NORM:
            begin
                if (m_reg[31])
                begin
                    it_next    = '0;
                    state_next = LG_SQ;
                end
                else
                begin
                    m_next = {m_reg[30:0], 1'b0};
                    k_next = k_reg - 1'b1;
                end
            end
            LG_SQ:
            begin
                frac_next = {frac_reg[18:0], sq_top[32]};
                m_next    = sq_top[32] ? sq_top[32:1] : sq_top[31:0];
                it_next   = it_reg + 1'b1;
                if (it_reg == 5'd19)
                begin
                    state_next = LG_SCALE;
                end
            end
            LG_SCALE:
            begin
                prod_next  = {32'd0, k_reg, frac_reg} * {25'd0, LN2_Q32};
                state_next = LG_ROUND;
            end
            LG_ROUND:
            begin
                ln_next    = rounded[36+LN_W-1:36];
                done_next  = 1'b1;
                state_next = LG_IDLE;
            end
            default:
            begin
                state_next = LG_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign ln   = ln_reg;
endmodule

FILE: rtl/core/thermistor_beta_temperature_unit.sv
`timescale 1ns / 1ps
// The time from the accepted last sample of a reading to m_tvalid is set by two
// bit-serial divides (38 quotient bits each) and the log unit (0 to 31 normalize
// shifts plus 20 squaring steps); a zero-sum reading goes straight to ST_OUT.
// Throughput: one sample per cycle between readings; input stalls while a reading
// computes and until its result is taken.
// Reset (rst_n, async, active low): clears accumulator, count and sequencer; registers
// return to series 2200, beta 63200, log_rx -264765.
module thermistor_beta_temperature_unit #(
    parameter int SAMPLES_PER_READING = 20,
    parameter int ADC_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] temp_tenths_c, [47:16] resistance_ohms,
                                   // [49:48] status
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);
    import tbt_pkg::*;

    localparam int CNT_W  = $clog2(SAMPLES_PER_READING + 1);
    localparam int SUM_W  = ADC_BITS + CNT_W;
    localparam int PROD_W = 20 + SUM_W;
    localparam int NUM_W  = (PROD_W > 38) ? PROD_W : 38;
    localparam int DEN_W  = (SUM_W > 25) ? SUM_W : 25;
    localparam logic [SUM_W-1:0] FULL = SUM_W'(SAMPLES_PER_READING) << ADC_BITS;
    localparam logic [15:0] ADC_MASK = 16'((32'd1 << ADC_BITS) - 1);

    tbt_state_t        state_reg, state_next;
    logic [19:0]       series_reg;
    logic [19:0]       beta_reg;
    logic [23:0]       rx_reg;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [SUM_W-1:0]  rd_sum_reg, rd_sum_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [31:0]       res_reg, res_next;
    logic [25:0]       d_reg, d_next;
    logic [15:0]       temp_reg, temp_next;
    logic [1:0]        stat_reg, stat_next;

    logic [15:0]       samp;
    logic [SUM_W-1:0]  sum_add;
    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;
    logic              log_start;
    logic              log_done;
    logic [LN_W-1:0]   log_ln;
    logic signed [25:0] diff;
    logic [NUM_W-1:0]  beta_num;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            series_reg <= 20'd2200;
            beta_reg   <= 20'd63200;
            rx_reg     <= 24'hFBF5C3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SERIES: series_reg <= cfg_wdata[19:0];
                CFG_BETA:   beta_reg   <= cfg_wdata[19:0];
                CFG_LOG_RX: rx_reg     <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_ACC;
            sum_reg    <= '0;
            cnt_reg    <= '0;
            rd_sum_reg <= '0;
            prod_reg   <= '0;
            res_reg    <= '0;
            d_reg      <= '0;
            temp_reg   <= '0;
            stat_reg   <= STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            sum_reg    <= sum_next;
            cnt_reg    <= cnt_next;
            rd_sum_reg <= rd_sum_next;
            prod_reg   <= prod_next;
            res_reg    <= res_next;
            d_reg      <= d_next;
            temp_reg   <= temp_next;
            stat_reg   <= stat_next;
        end
    end

    assign samp     = {4'd0, s_tdata[11:0]} & ADC_MASK;
    assign sum_add  = sum_reg + SUM_W'(samp);
    assign diff     = $signed({{(26-LN_W){1'b0}}, log_ln}) - $signed({{2{rx_reg[23]}}, rx_reg});
    assign beta_num = NUM_W'({beta_reg, 16'd0}) + NUM_W'({beta_reg, 14'd0})
                      + NUM_W'(d_reg[24:0]);

    // pick divider operands for the current divide
    always_comb
    begin
        div_start = (state_reg == ST_DIV1_GO) || (state_reg == ST_DIV2_GO);
        if (state_reg == ST_DIV2_GO)
        begin
            div_num = beta_num;
            div_den = DEN_W'({d_reg[24:0], 1'b0});
        end
        else
        begin
            div_num = NUM_W'(prod_reg);
            div_den = DEN_W'(rd_sum_reg);
        end
        log_start = (state_reg == ST_LOG_GO);
    end

    // reading sequencer
    always_comb
    begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        rd_sum_next = rd_sum_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;
        d_next      = d_reg;
        temp_next   = temp_reg;
        stat_next   = stat_reg;
        case (state_reg)
            ST_ACC:
            begin
                if (s_tvalid)
                begin
                    if (cnt_reg == CNT_W'(SAMPLES_PER_READING - 1))
                    begin
                        sum_next    = '0;
                        cnt_next    = '0;
                        rd_sum_next = sum_add;
                        temp_next   = '0;
                        stat_next   = STAT_OK;
                        if (sum_add == '0)
                        begin
                            res_next   = RES_MAX;
                            stat_next  = STAT_ZERO_SUM;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            state_next = ST_MUL;
                        end
                    end
                    else
                    begin
                        sum_next = sum_add;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = {{SUM_W{1'b0}}, series_reg} * {20'd0, FULL - rd_sum_reg};
                state_next = ST_DIV1_GO;
            end
            ST_DIV1_GO:
            begin
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    if (|div_quot[NUM_W-1:32])
                    begin
                        res_next   = RES_MAX;
                        stat_next  = STAT_SAT;
                        state_next = ST_LOG_GO;
                    end
                    else if (div_quot[31:0] == 32'd0)
                    begin
                        res_next   = '0;
                        stat_next  = STAT_LOG_NEG;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        res_next   = div_quot[31:0];
                        state_next = ST_LOG_GO;
                    end
                end
            end
            ST_LOG_GO:
            begin
                state_next = ST_LOG;
            end
            ST_LOG:
            begin
                if (log_done)
                begin
                    if (diff[25] || (diff == 26'sd0))
                    begin
                        stat_next  = STAT_LOG_NEG;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        d_next     = diff;
                        state_next = ST_DIV2_GO;
                    end
                end
            end
            ST_DIV2_GO:
            begin
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    if (div_quot > NUM_W'(TEMP_Q_LIMIT))
                    begin
                        temp_next = 16'h7FFF;
                        stat_next = STAT_SAT;
                    end
                    else
                    begin
                        temp_next = div_quot[15:0] - KELVIN_OFFSET;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    tbt_divider #(
        .NUM_W(NUM_W),
        .DEN_W(DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    tbt_log u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .start (log_start),
        .r     (res_reg),
        .done  (log_done),
        .ln    (log_ln)
    );

    assign s_tready = (state_reg == ST_ACC);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {6'd0, stat_reg, res_reg, temp_reg};

`include "thermistor_beta_temperature_unit_macros.svh"

    `TBT_ASSERT_IMP(a_no_take_while_out, m_tvalid, !s_tready)
    `TBT_ASSERT_IMP(a_zero_sum_open, m_tvalid && (m_tdata[49:48] == STAT_ZERO_SUM),
                    m_tdata[47:16] == RES_MAX)
    `TBT_ASSERT_IMP(a_log_neg_temp, m_tvalid && (m_tdata[49:48] == STAT_LOG_NEG),
                    m_tdata[15:0] == 16'd0)
    `TBT_ASSERT_NEXT(a_div_start_busy, div_start, !div_done)
endmodule
